FILE: src/lux_from_two_channel_light_core_defines.svh
// Assertion macros shared by the lux converter modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef LUX_FROM_TWO_CHANNEL_LIGHT_CORE_DEFINES_SVH
`define LUX_FROM_TWO_CHANNEL_LIGHT_CORE_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define LFL_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define LFL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lfl_pkg.sv
// Shared types, constants and coefficient tables of the lux converter.
// Used by every module of the block; depends on nothing.
package lfl_pkg;

    localparam int CH_W         = 16;
    localparam int FACTOR_W     = 19;
    localparam int CHS_FRAC     = 10;
    localparam int SCALE_PROD_W = CH_W + FACTOR_W;
    localparam int SCALED_W     = SCALE_PROD_W - CHS_FRAC;
    localparam int QUO_W        = 11;
    localparam int COEF_W       = 10;
    localparam int SEGMENTS     = 8;
    localparam int SEG_IDX_W    = 3;
    localparam int LUX_PROD_W   = SCALED_W + COEF_W;
    localparam int LUX_SUM_W    = LUX_PROD_W + 1;
    localparam int LUX_FRAC     = 14;
    localparam int LUX_FULL_W   = LUX_SUM_W - LUX_FRAC;
    localparam int LUX_W        = 16;

    localparam logic [FACTOR_W-1:0]  FACTOR_13MS  = 19'h07517;
    localparam logic [FACTOR_W-1:0]  FACTOR_101MS = 19'h00fe7;
    localparam logic [FACTOR_W-1:0]  FACTOR_UNITY = 19'h00400;
    localparam logic [LUX_SUM_W-1:0] LUX_ROUND   = LUX_SUM_W'(1) << (LUX_FRAC - 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_HIGH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_TIME   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKAGE_TYPE = 2'd2;

    localparam logic [1:0] ITIME_13MS  = 2'd0;
    localparam logic [1:0] ITIME_101MS = 2'd1;

    typedef struct packed {
        logic [CH_W-1:0] broadband_count;
        logic [CH_W-1:0] infrared_count;
    } in_word_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux_value;
        logic             lux_saturated;
    } out_word_t;

    typedef struct packed {
        logic       gain_high;
        logic [1:0] integration_time;
        logic       package_type;
    } cfg_t;

    // One word in flight through the ratio divider.
    typedef struct packed {
        logic [SCALED_W-1:0] s0;
        logic [SCALED_W-1:0] s1;
        logic [SCALED_W-1:0] rem;
        logic [QUO_W-1:0]    quo;
        logic                next_bit;
        logic                zero;
        logic                over;
        logic                pkg;
    } div_word_t;

    // Upper ratio bound of each segment, in Q9.
    function automatic logic [COEF_W-1:0] seg_limit(input logic pkg,
                                                   input logic [SEG_IDX_W-1:0] idx);
        logic [COEF_W-1:0] v;
        case ({pkg, idx})
            4'h0:    v = 10'h040;
            4'h1:    v = 10'h080;
            4'h2:    v = 10'h0c0;
            4'h3:    v = 10'h100;
            4'h4:    v = 10'h138;
            4'h5:    v = 10'h19a;
            4'h6:    v = 10'h29a;
            4'h8:    v = 10'h043;
            4'h9:    v = 10'h085;
            4'ha:    v = 10'h0c8;
            4'hb:    v = 10'h10a;
            4'hc:    v = 10'h14d;
            4'hd:    v = 10'h19a;
            4'he:    v = 10'h29a;
            default: v = 10'h3ff;
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] seg_offset(input logic pkg,
                                                    input logic [SEG_IDX_W-1:0] idx);
        logic [COEF_W-1:0] v;
        case ({pkg, idx})
            4'h0:    v = 10'h1f2;
            4'h1:    v = 10'h214;
            4'h2:    v = 10'h23f;
            4'h3:    v = 10'h270;
            4'h4:    v = 10'h16f;
            4'h5:    v = 10'h0d2;
            4'h6:    v = 10'h018;
            4'h8:    v = 10'h204;
            4'h9:    v = 10'h228;
            4'ha:    v = 10'h253;
            4'hb:    v = 10'h282;
            4'hc:    v = 10'h177;
            4'hd:    v = 10'h101;
            4'he:    v = 10'h037;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] seg_slope(input logic pkg,
                                                   input logic [SEG_IDX_W-1:0] idx);
        logic [COEF_W-1:0] v;
        case ({pkg, idx})
            4'h0:    v = 10'h1be;
            4'h1:    v = 10'h2d1;
            4'h2:    v = 10'h37b;
            4'h3:    v = 10'h3fe;
            4'h4:    v = 10'h1fc;
            4'h5:    v = 10'h0fb;
            4'h6:    v = 10'h012;
            4'h8:    v = 10'h1ad;
            4'h9:    v = 10'h2c1;
            4'ha:    v = 10'h363;
            4'hb:    v = 10'h3df;
            4'hc:    v = 10'h1dd;
            4'hd:    v = 10'h127;
            4'he:    v = 10'h02b;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/lfl_scale.sv
// Channel scaling and divider setup: two pipeline stages.
// Depends on lfl_pkg.
module lfl_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  lfl_pkg::cfg_t      cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  lfl_pkg::in_word_t  up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output lfl_pkg::div_word_t dn_data
);

    logic [lfl_pkg::FACTOR_W-1:0]     base;
    logic [lfl_pkg::FACTOR_W-1:0]     factor;
    logic [lfl_pkg::SCALE_PROD_W-1:0] prod0;
    logic [lfl_pkg::SCALE_PROD_W-1:0] prod1;
    logic [lfl_pkg::SCALED_W-1:0]     a_s0_next;
    logic [lfl_pkg::SCALED_W-1:0]     a_s1_next;

    logic                             a_valid_reg;
    logic [lfl_pkg::SCALED_W-1:0]     a_s0_reg;
    logic [lfl_pkg::SCALED_W-1:0]     a_s1_reg;
    logic                             a_pkg_reg;
    logic                             b_valid_reg;
    lfl_pkg::div_word_t               b_word_reg;
    lfl_pkg::div_word_t               b_word_next;

    logic ready_a;
    logic ready_b;

    always_comb
    begin
        case (cfg.integration_time)
            lfl_pkg::ITIME_13MS:  base = lfl_pkg::FACTOR_13MS;
            lfl_pkg::ITIME_101MS: base = lfl_pkg::FACTOR_101MS;
            default:              base = lfl_pkg::FACTOR_UNITY;
        endcase
        // Low gain reads sixteen times lower, so the factor grows by 16.
        factor = cfg.gain_high ? base : (base << 4);
    end

    assign prod0 = lfl_pkg::SCALE_PROD_W'(up_data.broadband_count)
                 * lfl_pkg::SCALE_PROD_W'(factor);
    assign prod1 = lfl_pkg::SCALE_PROD_W'(up_data.infrared_count)
                 * lfl_pkg::SCALE_PROD_W'(factor);
    assign a_s0_next = prod0[lfl_pkg::SCALE_PROD_W-1:lfl_pkg::CHS_FRAC];
    assign a_s1_next = prod1[lfl_pkg::SCALE_PROD_W-1:lfl_pkg::CHS_FRAC];

    // The quotient (s1 << 10) / s0 only matters below 2048, so the division
    // starts from s1 >> 1 and the overflow case is flagged up front.
    always_comb
    begin
        b_word_next.s0       = a_s0_reg;
        b_word_next.s1       = a_s1_reg;
        b_word_next.rem      = {1'b0, a_s1_reg[lfl_pkg::SCALED_W-1:1]};
        b_word_next.quo      = '0;
        b_word_next.next_bit = a_s1_reg[0];
        b_word_next.zero     = (a_s0_reg == '0);
        b_word_next.over     = ({1'b0, a_s1_reg} >= {a_s0_reg, 1'b0});
        b_word_next.pkg      = a_pkg_reg;
    end

    assign ready_b  = !b_valid_reg || dn_ready;
    assign ready_a  = !a_valid_reg || ready_b;
    assign up_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                a_valid_reg <= up_valid;
            end
            if (ready_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && up_valid)
        begin
            a_s0_reg  <= a_s0_next;
            a_s1_reg  <= a_s1_next;
            a_pkg_reg <= cfg.package_type;
        end
        if (ready_b && a_valid_reg)
        begin
            b_word_reg <= b_word_next;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_data  = b_word_reg;

endmodule

FILE: src/lfl_div_step.sv
// One restoring-division stage: one quotient bit per pipeline stage.
// Depends on lfl_pkg and the shared assertion macros.
`include "lux_from_two_channel_light_core_defines.svh"

module lfl_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  lfl_pkg::div_word_t up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output lfl_pkg::div_word_t dn_data
);

    logic [lfl_pkg::SCALED_W:0] shifted;
    logic [lfl_pkg::SCALED_W:0] diff;
    logic                       fits;
    lfl_pkg::div_word_t         word_next;
    lfl_pkg::div_word_t         word_reg;
    logic                       valid_reg;

    assign shifted = {up_data.rem, up_data.next_bit};
    assign diff    = shifted - {1'b0, up_data.s0};
    assign fits    = (shifted >= {1'b0, up_data.s0});

    always_comb
    begin
        word_next          = up_data;
        word_next.rem      = fits ? diff[lfl_pkg::SCALED_W-1:0]
                                  : shifted[lfl_pkg::SCALED_W-1:0];
        word_next.quo      = {up_data.quo[lfl_pkg::QUO_W-2:0], fits};
        // Only the first step brings in a dividend bit; the rest are zero.
        word_next.next_bit = 1'b0;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = word_reg;

    // For a quotient in range, the partial remainder stays below the divisor.
    `LFL_ASSERT_SAME(a_rem_below_divisor, valid_reg && !word_reg.zero && !word_reg.over, word_reg.rem < word_reg.s0, "lfl_div_step: remainder not below divisor")

endmodule

FILE: src/lfl_lux.sv
// Segment lookup, coefficient products, and rounding with saturation.
// Three pipeline stages; depends on lfl_pkg and the shared assertion macros.
`include "lux_from_two_channel_light_core_defines.svh"

module lfl_lux (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  lfl_pkg::div_word_t up_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lfl_pkg::out_word_t out_data
);

    logic [lfl_pkg::SEG_IDX_W-1:0]  seg;

    logic                           c_valid_reg;
    logic [lfl_pkg::SCALED_W-1:0]   c_s0_reg;
    logic [lfl_pkg::SCALED_W-1:0]   c_s1_reg;
    logic [lfl_pkg::COEF_W-1:0]     c_offset_reg;
    logic [lfl_pkg::COEF_W-1:0]     c_slope_reg;

    logic                           d_valid_reg;
    logic [lfl_pkg::LUX_PROD_W-1:0] d_pos_reg;
    logic [lfl_pkg::LUX_PROD_W-1:0] d_neg_reg;
    logic [lfl_pkg::LUX_PROD_W-1:0] d_pos_next;
    logic [lfl_pkg::LUX_PROD_W-1:0] d_neg_next;

    logic [lfl_pkg::LUX_PROD_W-1:0] diff;
    logic [lfl_pkg::LUX_SUM_W-1:0]  rounded;
    logic [lfl_pkg::LUX_FULL_W-1:0] lux_full;
    logic                           e_valid_reg;
    lfl_pkg::out_word_t             e_data_reg;
    lfl_pkg::out_word_t             e_data_next;

    logic ready_c;
    logic ready_d;
    logic ready_e;
    logic load_c;
    logic load_e;

    // The rounded ratio (q + 1) >> 1 is within a limit exactly when q is
    // within twice that limit, so the raw quotient is compared directly.
    always_comb
    begin
        seg = lfl_pkg::SEG_IDX_W'(lfl_pkg::SEGMENTS - 1);
        for (int i = lfl_pkg::SEGMENTS - 2; i >= 0; i--)
        begin
            if (up_data.quo <= {lfl_pkg::seg_limit(up_data.pkg, lfl_pkg::SEG_IDX_W'(i)), 1'b0})
            begin
                seg = lfl_pkg::SEG_IDX_W'(i);
            end
        end
        if (up_data.over)
        begin
            seg = lfl_pkg::SEG_IDX_W'(lfl_pkg::SEGMENTS - 1);
        end
        // A zero broadband term counts as ratio zero.
        if (up_data.zero)
        begin
            seg = '0;
        end
    end

    assign d_pos_next = lfl_pkg::LUX_PROD_W'(c_s0_reg) * lfl_pkg::LUX_PROD_W'(c_offset_reg);
    assign d_neg_next = lfl_pkg::LUX_PROD_W'(c_s1_reg) * lfl_pkg::LUX_PROD_W'(c_slope_reg);

    always_comb
    begin
        diff     = (d_pos_reg > d_neg_reg) ? (d_pos_reg - d_neg_reg) : '0;
        rounded  = lfl_pkg::LUX_SUM_W'(diff) + lfl_pkg::LUX_ROUND;
        lux_full = rounded[lfl_pkg::LUX_SUM_W-1:lfl_pkg::LUX_FRAC];
        e_data_next.lux_saturated = |lux_full[lfl_pkg::LUX_FULL_W-1:lfl_pkg::LUX_W];
        e_data_next.lux_value     = e_data_next.lux_saturated ? '1
                                    : lux_full[lfl_pkg::LUX_W-1:0];
    end

    assign ready_e  = !e_valid_reg || !out_stall;
    assign ready_d  = !d_valid_reg || ready_e;
    assign ready_c  = !c_valid_reg || ready_d;
    assign up_ready = ready_c;
    assign load_c   = ready_c && up_valid;
    assign load_e   = ready_e && d_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_c)
            begin
                c_valid_reg <= up_valid;
            end
            if (ready_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (ready_e)
            begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_c)
        begin
            c_s0_reg     <= up_data.s0;
            c_s1_reg     <= up_data.s1;
            c_offset_reg <= lfl_pkg::seg_offset(up_data.pkg, seg);
            c_slope_reg  <= lfl_pkg::seg_slope(up_data.pkg, seg);
        end
        if (ready_d && c_valid_reg)
        begin
            d_pos_reg <= d_pos_next;
            d_neg_reg <= d_neg_next;
        end
        if (load_e)
        begin
            e_data_reg <= e_data_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_data  = e_data_reg;

    // A ratio beyond the last segment selects zero coefficients.
    `LFL_ASSERT_NEXT(a_steep_ratio_zero_coef, load_c && up_data.over && !up_data.zero, c_offset_reg == '0 && c_slope_reg == '0, "lfl_lux: coefficients not zero above last segment")

    // A non-positive difference must give zero lux without saturation.
    `LFL_ASSERT_NEXT(a_clamp_gives_zero, load_e && (d_pos_reg <= d_neg_reg), e_data_reg.lux_value == '0 && !e_data_reg.lux_saturated, "lfl_lux: clamped difference did not give zero")

endmodule

FILE: src/lux_from_two_channel_light_core.sv
// Usage notes:
// Converts a broadband and an infrared photodiode count into lux with a
// piecewise-linear approximation. The input channel (in_valid, in_stall,
// in_data) takes one word per cycle while not stalled; the output channel
// (out_valid, out_stall, out_data) returns exactly one word per input word,
// in order. Each word passes two scaling stages, eleven divider stages
// that each resolve one bit of the Q10 ratio, then segment lookup,
// coefficient products and rounding. Throughput is one word per cycle
// while out_stall is low; every stage, each divider step included, takes
// a new word whenever the stage after it moves.
// A stalled output holds its word; upstream stages keep accepting until
// every stage is full, so in_stall only rises when no bubble is left.
// The configuration port (cfg_wr_en, cfg_index, cfg_data) writes gain,
// integration time and package type; write it only while no word is in
// flight. Unknown indexes are ignored.
// Reset clears all valid bits and sets every configuration register to 0.
// Depends on lfl_pkg, lfl_scale, lfl_div_step and lfl_lux.
module lux_from_two_channel_light_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lfl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  lfl_pkg::in_word_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output lfl_pkg::out_word_t              out_data
);

    lfl_pkg::cfg_t      cfg_reg;
    logic               scale_ready;

    logic               stp_valid [lfl_pkg::QUO_W+1];
    logic               stp_ready [lfl_pkg::QUO_W+1];
    lfl_pkg::div_word_t stp_data  [lfl_pkg::QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lfl_pkg::REG_GAIN_HIGH:    cfg_reg.gain_high        <= cfg_data[0];
                lfl_pkg::REG_INTEG_TIME:   cfg_reg.integration_time <= cfg_data[1:0];
                lfl_pkg::REG_PACKAGE_TYPE: cfg_reg.package_type     <= cfg_data[0];
                default:                   cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    lfl_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (in_valid),
        .up_ready (scale_ready),
        .up_data  (in_data),
        .dn_valid (stp_valid[0]),
        .dn_ready (stp_ready[0]),
        .dn_data  (stp_data[0])
    );

    assign in_stall = !scale_ready;

    for (genvar k = 0; k < lfl_pkg::QUO_W; k++)
    begin : g_div
        lfl_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stp_valid[k]),
            .up_ready (stp_ready[k]),
            .up_data  (stp_data[k]),
            .dn_valid (stp_valid[k+1]),
            .dn_ready (stp_ready[k+1]),
            .dn_data  (stp_data[k+1])
        );
    end

    lfl_lux u_lux (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (stp_valid[lfl_pkg::QUO_W]),
        .up_ready  (stp_ready[lfl_pkg::QUO_W]),
        .up_data   (stp_data[lfl_pkg::QUO_W]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: dv/lux_from_two_channel_light_core_checker.sv
`timescale 1ns / 1ps
// Checker for the lux converter: tracks register writes, predicts the lux word for
// every accepted input word and compares the returned words in order.
// Depends on lfl_pkg for the word types, register indexes and time codes.
module lux_from_two_channel_light_core_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lfl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  lfl_pkg::in_word_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  lfl_pkg::out_word_t              out_data,
    output int                              fail_count,
    output int                              pending,
    output int                              checked,
    output int                              saturated,
    output int                              zeroed
);

    localparam int RATIO_Q = 9;

    localparam logic [9:0] LIMIT_TBL [0:1][0:6] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
    };
    localparam logic [9:0] OFFSET_TBL [0:1][0:7] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
    };
    localparam logic [9:0] SLOPE_TBL [0:1][0:7] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
    };

    logic               gain_q;
    logic [1:0]         itime_q;
    logic               pkg_q;
    lfl_pkg::out_word_t lux_expected_q [$];
    lfl_pkg::out_word_t want;
    int                 fails;
    int                 seen;
    int                 sat_seen;
    int                 zero_seen;

    function automatic lfl_pkg::out_word_t predict_lux(input lfl_pkg::in_word_t w,
                                                       input logic gain,
                                                       input logic [1:0] itime,
                                                       input logic pkg);
        longint unsigned    ch0, ch1, factor, s0, s1, ratio, pos, neg, diff, lux;
        int                 seg, i;
        lfl_pkg::out_word_t r;
        ch0 = w.broadband_count;
        ch1 = w.infrared_count;
        case (itime)
            lfl_pkg::ITIME_13MS:  factor = 64'h7517;
            lfl_pkg::ITIME_101MS: factor = 64'h0fe7;
            default:              factor = 64'd1 << lfl_pkg::CHS_FRAC;
        endcase
        // At 1x gain the counts are brought up to the 16x scale.
        if (!gain)
            factor = factor << 4;
        s0 = (ch0 * factor) >> lfl_pkg::CHS_FRAC;
        s1 = (ch1 * factor) >> lfl_pkg::CHS_FRAC;
        ratio = (s0 != 0) ? (s1 << (RATIO_Q + 1)) / s0 : 64'd0;
        ratio = (ratio + 1) >> 1;
        seg = 7;
        for (i = 6; i >= 0; i--)
            if (ratio <= LIMIT_TBL[pkg][i])
                seg = i;
        pos  = s0 * OFFSET_TBL[pkg][seg];
        neg  = s1 * SLOPE_TBL[pkg][seg];
        diff = (pos > neg) ? pos - neg : 64'd0;
        lux  = (diff + (64'd1 << (lfl_pkg::LUX_FRAC - 1))) >> lfl_pkg::LUX_FRAC;
        r.lux_saturated = (lux > 64'hffff);
        r.lux_value     = r.lux_saturated ? 16'hffff : lux[15:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            gain_q  = 1'b0;
            itime_q = 2'd0;
            pkg_q   = 1'b0;
            lux_expected_q.delete();
            fails     = 0;
            seen      = 0;
            sat_seen  = 0;
            zero_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                lux_expected_q.push_back(predict_lux(in_data, gain_q, itime_q, pkg_q));
            if (out_valid && !out_stall)
            begin
                seen++;
                if (out_data.lux_saturated)
                    sat_seen++;
                if (out_data.lux_value == '0)
                    zero_seen++;
                if (lux_expected_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected lux word, expected none, got value %0d sat %0b",
                             $time, out_data.lux_value, out_data.lux_saturated);
                end
                else
                begin
                    want = lux_expected_q.pop_front();
                    if (out_data.lux_value !== want.lux_value)
                    begin
                        fails++;
                        $display("%0t: lux_value mismatch, expected %0d, got %0d",
                                 $time, want.lux_value, out_data.lux_value);
                    end
                    if (out_data.lux_saturated !== want.lux_saturated)
                    begin
                        fails++;
                        $display("%0t: lux_saturated mismatch, expected %0b, got %0b",
                                 $time, want.lux_saturated, out_data.lux_saturated);
                    end
                end
            end
            // Writes land only while nothing is in flight, so the order here is free.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lfl_pkg::REG_GAIN_HIGH:    gain_q  = cfg_data[0];
                    lfl_pkg::REG_INTEG_TIME:   itime_q = cfg_data;
                    lfl_pkg::REG_PACKAGE_TYPE: pkg_q   = cfg_data[0];
                    default:                   ;
                endcase
            end
        end
        fail_count <= fails;
        pending    <= lux_expected_q.size();
        checked    <= seen;
        saturated  <= sat_seen;
        zeroed     <= zero_seen;
    end

endmodule

FILE: dv/lux_from_two_channel_light_core_tb.sv
`timescale 1ns / 1ps
// Top of the lux converter testbench: clock, reset, register writes and the
// word traffic on both channels. Depends on lfl_pkg, the core and the checker.
module lux_from_two_channel_light_core_tb;

    localparam int LATENCY           = 16;
    localparam int HOLD_CYCLES       = 64;
    localparam int SEGMENT_COUNT     = 12;
    localparam int WORDS_PER_SEGMENT = 46;
    localparam int CYCLE_LIMIT       = 400000;

    localparam logic [lfl_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [lfl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lfl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    lfl_pkg::in_word_t               in_data   = '0;
    logic                            out_stall = 1'b0;
    logic                            in_stall;
    logic                            out_valid;
    lfl_pkg::out_word_t              out_data;

    int send_idle_pct  = 34;
    int recv_idle_pct  = 84;
    int hold_requests  = 0;
    int holds_granted  = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int settings_done  = 0;
    int fail_count;
    int pending;
    int checked;
    int saturated;
    int zeroed;

    always #5 clk = ~clk;

    lux_from_two_channel_light_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    lux_from_two_channel_light_core_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .saturated  (saturated),
        .zeroed     (zeroed)
    );

    // Output side: a requested hold stalls for a fixed stretch, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_granted != hold_requests)
        begin
            out_stall     <= 1'b1;
            hold_left     <= HOLD_CYCLES - 1;
            holds_granted <= holds_granted + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic offer_light_word(input logic [15:0] ch0, input logic [15:0] ch1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid                <= 1'b1;
        in_data.broadband_count <= ch0;
        in_data.infrared_count  <= ch1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_lux_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Upper data bits of the one-bit registers are set at random; the block masks them.
    task automatic program_light_cfg(input logic gain, input logic [1:0] itime,
                                     input logic pkg);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= lfl_pkg::CFG_DATA_W'($urandom_range(3));
        @(posedge clk);
        cfg_index <= lfl_pkg::REG_GAIN_HIGH;
        cfg_data  <= {$urandom_range(1) == 1, gain};
        @(posedge clk);
        cfg_index <= lfl_pkg::REG_INTEG_TIME;
        cfg_data  <= itime;
        @(posedge clk);
        cfg_index <= lfl_pkg::REG_PACKAGE_TYPE;
        cfg_data  <= {$urandom_range(1) == 1, pkg};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_done++;
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned ch0, ch1, ratio_q9, pick;
        int          seg, n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings: field extremes, zero broadband,
        // saturation, ratios far above the last segment and on each segment edge.
        offer_light_word(16'd0, 16'd0);
        offer_light_word(16'd0, 16'd65535);
        offer_light_word(16'd65535, 16'd0);
        offer_light_word(16'd65535, 16'd65535);
        offer_light_word(16'd65535, 16'd30000);
        offer_light_word(16'd1, 16'd0);
        offer_light_word(16'd0, 16'd1);
        offer_light_word(16'd1, 16'd1);
        offer_light_word(16'd1, 16'd65535);
        offer_light_word(16'd100, 16'd200);
        offer_light_word(16'd7000, 16'd100);
        offer_light_word(16'd4096, 16'd512);
        offer_light_word(16'd4096, 16'd520);
        offer_light_word(16'd4096, 16'd1024);
        offer_light_word(16'd4096, 16'd1536);
        offer_light_word(16'd4096, 16'd2048);
        offer_light_word(16'd4096, 16'd2496);
        offer_light_word(16'd4096, 16'd3280);
        offer_light_word(16'd4096, 16'd5328);
        offer_light_word(16'd4096, 16'd5336);
        wait_lux_drained();

        for (seg = 0; seg < SEGMENT_COUNT; seg++)
        begin
            if (seg < SEGMENT_COUNT / 3)
            begin
                send_idle_pct <= 34;
                recv_idle_pct <= 84;
            end
            else if (seg < 2 * SEGMENT_COUNT / 3)
            begin
                send_idle_pct <= 84;
                recv_idle_pct <= 34;
            end
            else
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            program_light_cfg(1'(seg % 2), 2'((seg / 2) % 4), seg % 3 == 1);
            for (n = 0; n < WORDS_PER_SEGMENT; n++)
            begin
                // With no idling, a long output hold fills the pipeline and stalls the input.
                if (seg == 2 * SEGMENT_COUNT / 3 && n == 4)
                    hold_requests <= hold_requests + 1;
                if (seg == 5 && n == WORDS_PER_SEGMENT / 2)
                    wait_lux_drained();
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    ch0 = $urandom_range(65535);
                    ch1 = $urandom_range(65535);
                end
                else if (pick < 75)
                begin
                    // Infrared set by a chosen Q9 ratio, reaching past the last segment.
                    ch0      = $urandom_range(65535);
                    ratio_q9 = $urandom_range(720);
                    ch1      = (ch0 * ratio_q9) >> 9;
                    if (ch1 > 65535)
                        ch1 = 65535;
                end
                else if (pick < 85)
                begin
                    ch0 = $urandom_range(15);
                    ch1 = $urandom_range(15);
                end
                else
                begin
                    ch0 = $urandom_range(65535, 60000);
                    ch1 = $urandom_range(ch0 / 4);
                end
                offer_light_word(ch0[15:0], ch1[15:0]);
            end
            wait_lux_drained();
        end

        repeat (2 * LATENCY) @(posedge clk);
        $display("Run covered %0d lux words over %0d register settings and three idle mixes.",
                 checked, settings_done);
        $display("%0d words saturated, %0d came back as zero, %0d long output holds.",
                 saturated, zeroed, holds_granted);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
